@@ hw/rtl/rpc_pkg.sv @@
// Package for the RMAP reply packet checker: widths, header positions,
// instruction and failure bit codes, the snapshot struct and the CRC-8 step.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rpc_pkg;

    // Byte counter width (saturating count of packet bytes, up to 2^25-1)
    localparam int LENGTH_BITS = 25;
    // Width used for the data-length plus header compare
    localparam int DLEN_SUM_W  = 25;
    localparam int FAIL_W      = 10;
    localparam int CFG_IDX_W   = 2;

    typedef logic [LENGTH_BITS-1:0] t_count;
    typedef logic [DLEN_SUM_W-1:0]  t_dsum;
    typedef logic [FAIL_W-1:0]      t_fail;
    typedef logic [CFG_IDX_W-1:0]   t_cfg_idx;

    localparam t_count COUNT_MAX = {LENGTH_BITS{1'b1}};

    // Header byte positions in a reply packet
    localparam t_count POS_DEST    = t_count'(0);
    localparam t_count POS_PROTO   = t_count'(1);
    localparam t_count POS_INSTR   = t_count'(2);
    localparam t_count POS_STATUS  = t_count'(3);
    localparam t_count POS_SOURCE  = t_count'(4);
    localparam t_count POS_TID_HI  = t_count'(5);
    localparam t_count POS_TID_LO  = t_count'(6);
    localparam t_count POS_DLEN_HI = t_count'(8);
    localparam t_count POS_DLEN_MD = t_count'(9);
    localparam t_count POS_DLEN_LO = t_count'(10);
    localparam t_count POS_HDR_END = t_count'(11);

    // Packet lengths
    localparam t_count LEN_WRITE_REPLY = t_count'(8);
    localparam t_count LEN_MIN_READ    = t_count'(13);
    localparam t_dsum  DSUM_HDR_LEN    = t_dsum'(13);

    // Header constants
    localparam logic [7:0] PROTOCOL_RMAP      = 8'h01;
    localparam logic [7:0] STATUS_UNUSED_TYPE = 8'h02;

    // Instruction field bits
    localparam logic [7:0] INS_TYPE_MASK = 8'hC0;
    localparam int         INS_WRITE     = 5;
    localparam int         INS_VERIFY    = 4;
    localparam int         INS_REPLY     = 3;
    localparam logic [7:0] INS_ADDR_MASK = 8'h03;

    // Failure mask bit positions
    localparam int FB_EEP      = 0;
    localparam int FB_TRUNC    = 1;
    localparam int FB_LENGTH   = 2;
    localparam int FB_CRC      = 3;
    localparam int FB_DEST     = 4;
    localparam int FB_PROTO    = 5;
    localparam int FB_INSTR    = 6;
    localparam int FB_REJECTED = 7;
    localparam int FB_SOURCE   = 8;
    localparam int FB_DLEN     = 9;

    // Configuration register indexes
    localparam t_cfg_idx CFG_OWN_ADDRESS    = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_TARGET_ADDRESS = t_cfg_idx'(1);

    // Final packet state handed from the accumulator to the checker
    typedef struct packed {
        t_count      len;
        logic        crc_zero;
        logic        hdr_crc_zero;
        logic        eep;
        logic        trunc;
        logic [7:0]  dest;
        logic [7:0]  proto;
        logic [7:0]  instr;
        logic [7:0]  status;
        logic [7:0]  source;
        logic [15:0] tid;
        logic [23:0] dlen;
    } t_snap;

    // One byte of the RMAP CRC-8 (reflected x^8+x^2+x+1, LSB first)
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 8'hE0;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rpc_in_if.sv @@
// Input channel of the RMAP reply packet checker: one packet byte per transaction.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       ended_by_eep;
    logic       was_truncated;

    modport source (output valid, data_byte, last_byte, ended_by_eep, was_truncated,
                    input ready);
    modport sink   (input valid, data_byte, last_byte, ended_by_eep, was_truncated,
                    output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rpc_out_if.sv @@
// Result channel of the RMAP reply packet checker: one verdict per packet.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface rpc_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  fail_mask;
    logic        reply_good;
    logic [7:0]  reply_instruction;
    logic [7:0]  reply_status;
    logic [15:0] transaction_id;
    logic [23:0] reply_data_length;

    modport source (output valid, fail_mask, reply_good, reply_instruction, reply_status,
                    transaction_id, reply_data_length, input ready);
    modport sink   (input valid, fail_mask, reply_good, reply_instruction, reply_status,
                    transaction_id, reply_data_length, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/rpc_accum.sv @@
// Per-byte accumulator: running CRC, saturating byte count, header capture.
// On the last byte it registers a snapshot of the packet and clears itself.
// Depends on rpc_pkg and rpc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module rpc_accum
    import rpc_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    rpc_in_if.sink i_in,
    input  wire   i_snap_ready,
    output logic  o_snap_valid,
    output t_snap o_snap
);

    logic [7:0]  r_crc, n_crc;
    logic        r_hcz, n_hcz;
    t_count      r_count, n_count;
    logic [7:0]  r_dest, n_dest;
    logic [7:0]  r_proto, n_proto;
    logic [7:0]  r_instr, n_instr;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_source, n_source;
    logic [15:0] r_tid, n_tid;
    logic [23:0] r_dlen, n_dlen;
    logic        r_snap_valid;
    t_snap       r_snap, n_snap;
    logic        in_acc;

    // Take a byte unless a finished snapshot is stuck
    assign i_in.ready = !r_snap_valid || i_snap_ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // Header capture by byte position
    always_comb begin
        n_dest   = r_dest;
        n_proto  = r_proto;
        n_instr  = r_instr;
        n_status = r_status;
        n_source = r_source;
        n_tid    = r_tid;
        n_dlen   = r_dlen;
        unique case (r_count)
            POS_DEST:    n_dest        = i_in.data_byte;
            POS_PROTO:   n_proto       = i_in.data_byte;
            POS_INSTR:   n_instr       = i_in.data_byte;
            POS_STATUS:  n_status      = i_in.data_byte;
            POS_SOURCE:  n_source      = i_in.data_byte;
            POS_TID_HI:  n_tid[15:8]   = i_in.data_byte;
            POS_TID_LO:  n_tid[7:0]    = i_in.data_byte;
            POS_DLEN_HI: n_dlen[23:16] = i_in.data_byte;
            POS_DLEN_MD: n_dlen[15:8]  = i_in.data_byte;
            POS_DLEN_LO: n_dlen[7:0]   = i_in.data_byte;
            default: ;
        endcase
    end

    // CRC, header CRC flag and saturating count
    always_comb begin
        n_crc   = crc8_update(r_crc, i_in.data_byte);
        n_hcz   = (r_count == POS_HDR_END) ? (n_crc == 8'h00) : r_hcz;
        n_count = (r_count != COUNT_MAX) ? r_count + t_count'(1) : r_count;
    end

    // Snapshot of the finished packet
    always_comb begin
        n_snap.len          = n_count;
        n_snap.crc_zero     = (n_crc == 8'h00);
        n_snap.hdr_crc_zero = n_hcz;
        n_snap.eep          = i_in.ended_by_eep;
        n_snap.trunc        = i_in.was_truncated;
        n_snap.dest         = n_dest;
        n_snap.proto        = n_proto;
        n_snap.instr        = n_instr;
        n_snap.status       = n_status;
        n_snap.source       = n_source;
        n_snap.tid          = n_tid;
        n_snap.dlen         = n_dlen;
    end

    // Running packet state; cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= '0;
            r_hcz    <= 1'b0;
            r_count  <= '0;
            r_dest   <= '0;
            r_proto  <= '0;
            r_instr  <= '0;
            r_status <= '0;
            r_source <= '0;
            r_tid    <= '0;
            r_dlen   <= '0;
        end else if (in_acc) begin
            if (i_in.last_byte) begin
                r_crc    <= '0;
                r_hcz    <= 1'b0;
                r_count  <= '0;
                r_dest   <= '0;
                r_proto  <= '0;
                r_instr  <= '0;
                r_status <= '0;
                r_source <= '0;
                r_tid    <= '0;
                r_dlen   <= '0;
            end else begin
                r_crc    <= n_crc;
                r_hcz    <= n_hcz;
                r_count  <= n_count;
                r_dest   <= n_dest;
                r_proto  <= n_proto;
                r_instr  <= n_instr;
                r_status <= n_status;
                r_source <= n_source;
                r_tid    <= n_tid;
                r_dlen   <= n_dlen;
            end
        end
    end

    // Snapshot handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (in_acc && i_in.last_byte) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_ready) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.last_byte) begin
            r_snap <= n_snap;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule

`default_nettype wire

@@ hw/rtl/rpc_check.sv @@
// Verdict stage: evaluates the packet snapshot and holds the result in the
// output register until the receiver takes it. Depends on rpc_pkg and rpc_out_if.
`timescale 1ns / 1ps
`default_nettype none

module rpc_check
    import rpc_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_snap_valid,
    input  t_snap   i_snap,
    output logic    o_snap_ready,
    input  wire [7:0] i_own_address,
    input  wire [7:0] i_target_address,
    rpc_out_if.source o_out
);

    logic        r_valid;
    t_fail       r_fail, n_fail;
    logic [7:0]  r_instr, r_status;
    logic [15:0] r_tid;
    logic [23:0] r_dlen, n_dlen;
    logic        len8, len_ok, crc_ok, ins_odd;
    t_dsum       dsum;
    logic        load;

    assign o_snap_ready = !r_valid || o_out.ready;
    assign load         = i_snap_valid && o_snap_ready;

    // Failure mask, in priority order
    always_comb begin
        len8    = (i_snap.len == LEN_WRITE_REPLY);
        len_ok  = len8 || (i_snap.len >= LEN_MIN_READ);
        crc_ok  = i_snap.crc_zero && (len8 || i_snap.hdr_crc_zero);
        dsum    = t_dsum'(i_snap.dlen) + DSUM_HDR_LEN;
        ins_odd = !i_snap.instr[INS_REPLY]
                  || (i_snap.instr[INS_VERIFY] && !i_snap.instr[INS_WRITE])
                  || ((i_snap.instr & INS_ADDR_MASK) != 8'h00);
        n_fail  = '0;
        priority if (i_snap.eep) begin
            n_fail[FB_EEP] = 1'b1;
        end else if (i_snap.trunc) begin
            n_fail[FB_TRUNC] = 1'b1;
        end else if (!len_ok) begin
            n_fail[FB_LENGTH] = 1'b1;
        end else if (!crc_ok) begin
            n_fail[FB_CRC] = 1'b1;
        end else begin
            n_fail[FB_DEST]  = (i_snap.dest != i_own_address);
            n_fail[FB_PROTO] = (i_snap.proto != PROTOCOL_RMAP);
            if ((i_snap.instr & INS_TYPE_MASK) != 8'h00) begin
                n_fail[FB_INSTR] = 1'b1;
            end else if (ins_odd) begin
                if (i_snap.status == STATUS_UNUSED_TYPE) begin
                    n_fail[FB_REJECTED] = 1'b1;
                end else begin
                    n_fail[FB_INSTR] = 1'b1;
                end
            end
            // Write replies are exactly eight bytes, read replies never are
            if (i_snap.instr[INS_WRITE] == !len8) begin
                n_fail[FB_INSTR] = 1'b1;
            end
            n_fail[FB_SOURCE] = (i_snap.source != i_target_address);
            n_fail[FB_DLEN]   = !len8 && (dsum != t_dsum'(i_snap.len));
        end
        n_dlen = len8 ? 24'h000000 : i_snap.dlen;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_fail   <= n_fail;
            r_instr  <= i_snap.instr;
            r_status <= i_snap.status;
            r_tid    <= i_snap.tid;
            r_dlen   <= n_dlen;
        end
    end

    assign o_out.valid             = r_valid;
    assign o_out.fail_mask         = r_fail;
    assign o_out.reply_good        = (r_fail == '0);
    assign o_out.reply_instruction = r_instr;
    assign o_out.reply_status      = r_status;
    assign o_out.transaction_id    = r_tid;
    assign o_out.reply_data_length = r_dlen;

endmodule

`default_nettype wire

@@ hw/rtl/rmap_reply_packet_checker.sv @@
// RMAP reply packet checker, top level: configuration registers, accumulator
// and verdict stage. Depends on rpc_pkg, rpc_in_if, rpc_out_if, rpc_accum, rpc_check.
//
// Usage:
//   i_in carries one reply packet byte per transaction, header first; the
//   final byte has last_byte set, with ended_by_eep and was_truncated.
//   o_out carries one verdict per packet: the failure mask, a good flag and
//   the captured instruction, status, transaction id and data length.
//   i_cfg_we/i_cfg_idx/i_cfg_wdata write own_address (index 0) and
//   target_address (index 1); both reset to 254. Write only while idle.
// Timing:
//   One byte per clock is taken while i_in.ready is high. The snapshot register
//   loads at the edge that accepts the last byte; the output register loads
//   from it once it is empty or o_out is taken, and then o_out.valid rises.
//   Both stages hold one packet each.
// Reset and stall:
//   Synchronous reset clears the running CRC, count and header capture and
//   empties both stages. While o_out is stalled, bytes of the next packet
//   keep flowing until a second finished packet waits in the snapshot
//   register; i_in.ready then drops until the output is taken.
`timescale 1ns / 1ps
`default_nettype none

module rmap_reply_packet_checker
    import rpc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    rpc_in_if.sink     i_in,
    rpc_out_if.source  o_out,
    input  wire        i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [7:0]  i_cfg_wdata
);

    logic [7:0] r_own_address;
    logic [7:0] r_target_address;
    logic       snap_valid;
    logic       snap_ready;
    t_snap      snap;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_address    <= 8'd254;
            r_target_address <= 8'd254;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_OWN_ADDRESS) begin
                r_own_address <= i_cfg_wdata;
            end
            if (i_cfg_idx == CFG_TARGET_ADDRESS) begin
                r_target_address <= i_cfg_wdata;
            end
        end
    end

    rpc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_snap_ready (snap_ready),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    rpc_check u_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap_valid     (snap_valid),
        .i_snap           (snap),
        .o_snap_ready     (snap_ready),
        .i_own_address    (r_own_address),
        .i_target_address (r_target_address),
        .o_out            (o_out)
    );

    // Good flag agrees with the mask
    a_good_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.reply_good == (o_out.fail_mask == '0)))
        else $error("reply_good disagrees with fail_mask");

    // Framing and CRC failures are reported alone
    a_early_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.fail_mask[FB_CRC:FB_EEP] != '0)) |->
        $onehot(o_out.fail_mask))
        else $error("framing or CRC failure combined with other bits");

    // A waiting snapshot that cannot move blocks the input
    a_snap_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (snap_valid && !snap_ready) |-> !i_in.ready)
        else $error("input accepted while a packet snapshot is stuck");

    // A write reply never reports a data length
    a_write_dlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (snap_valid && snap_ready && (snap.len == LEN_WRITE_REPLY)) |=>
        (o_out.reply_data_length == 24'h000000))
        else $error("write reply with nonzero data length");

endmodule

`default_nettype wire
